FILE: design/pfc_pkg.sv
package pfc_pkg;

   localparam int unsigned SIDE       = 5;
   localparam int unsigned CELLS      = SIDE * SIDE;
   localparam int unsigned CODE_W     = 5;
   localparam int unsigned POS_W      = 3;
   localparam int unsigned IDX_W      = 5;
   localparam int unsigned ROWS2_W    = 2 * SIDE * CODE_W;
   localparam int unsigned ROW_W      = SIDE * CODE_W;
   localparam int unsigned SQUARE_W   = CELLS * CODE_W;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(SIDE - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_0_1 = 2'd0,
      CSR_ROWS_2_3 = 2'd1,
      CSR_ROW_4    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] first_letter;
      logic [CODE_W-1:0] second_letter;
      logic              mode;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] first_out;
      logic [CODE_W-1:0] second_out;
      logic              not_found;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_type;

   // one-hot (five wide) to position; zero maps to zero
   function automatic logic [POS_W-1:0] onehot_to_pos(input logic [SIDE-1:0] sel);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < SIDE; i++) begin
         if (sel[i]) pos = pos | POS_W'(i);
      end
      return pos;
   endfunction

   // move one place with wrap: forward to encrypt, back to decrypt
   function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] pos,
                                                 input logic             dec);
      logic [POS_W-1:0] nxt;
      if (dec) nxt = (pos == '0) ? LAST_POS : pos - POS_W'(1);
      else     nxt = (pos == LAST_POS) ? '0 : pos + POS_W'(1);
      return nxt;
   endfunction

   function automatic logic [CODE_W-1:0] cell_pick(input logic [SQUARE_W-1:0] square,
                                                   input logic [POS_W-1:0]    row,
                                                   input logic [POS_W-1:0]    col);
      logic [IDX_W-1:0] idx;
      idx = {row[IDX_W-3:0], 2'b00} + IDX_W'(row) + IDX_W'(col);
      return square[idx * CODE_W +: CODE_W];
   endfunction

endpackage

FILE: design/pfc_locate.sv
module pfc_locate
   import pfc_pkg::*;
(
   input  logic [CELLS-1:0] hit,
   output pos_type          pos
);

   logic [CELLS-1:0] first_hit;
   logic [SIDE-1:0]  row_sel;
   logic [SIDE-1:0]  col_sel;

   // isolate the lowest set bit: first match in row-major order
   assign first_hit = hit & (~hit + CELLS'(1));

   always_comb begin
      row_sel = '0;
      col_sel = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            row_sel[r] = row_sel[r] | first_hit[r * SIDE + c];
            col_sel[c] = col_sel[c] | first_hit[r * SIDE + c];
         end
      end
   end

   assign pos.found = |hit;
   assign pos.row   = onehot_to_pos(row_sel);
   assign pos.col   = onehot_to_pos(col_sel);

endmodule

FILE: design/playfair_digraph_cipher_unit.sv
// Channel   Ports                                  Transaction
// request   start, busy, req_data                  start high and busy low at a clock edge
// result    rsp_valid, rsp_data                    rsp_valid high for one cycle, always taken
// csr       csr_valid, csr_ready, csr_index/data   csr_valid and csr_ready both high
//
// Three register stages: cell compare, first-match position, rule and cell select.
// A digraph enters every cycle while busy is low; its result passes through the s1, s2
// and s3 registers to the outputs, where the receiver accepts it.
// Synchronous reset clears the valid bits and the key square; busy is high for the
// cycle after reset and low otherwise. Nothing stalls: the receiver takes every result.
module playfair_digraph_cipher_unit
   import pfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROWS2_W-1:0]   csr_data
);

   logic [ROWS2_W-1:0]  sq01_ff;
   logic [ROWS2_W-1:0]  sq23_ff;
   logic [ROW_W-1:0]    sq4_ff;
   logic [SQUARE_W-1:0] square;
   logic                busy_ff;

   logic                s1_valid_ff;
   req_type             s1_req_ff;
   logic [CELLS-1:0]    s1_hit_a_ff;
   logic [CELLS-1:0]    s1_hit_b_ff;
   logic [CELLS-1:0]    hit_a_in;
   logic [CELLS-1:0]    hit_b_in;

   logic                s2_valid_ff;
   req_type             s2_req_ff;
   pos_type             s2_pos_a_ff;
   pos_type             s2_pos_b_ff;
   pos_type             pos_a_in;
   pos_type             pos_b_in;

   logic                s3_valid_ff;
   rsp_type             s3_rsp_ff;
   rsp_type             rsp_in;

   assign square    = {sq4_ff, sq23_ff, sq01_ff};
   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq01_ff <= '0;
         sq23_ff <= '0;
         sq4_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS_0_1: sq01_ff <= csr_data;
            CSR_ROWS_2_3: sq23_ff <= csr_data;
            CSR_ROW_4:    sq4_ff  <= csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // stage 1: compare both letters against every cell
   always_comb begin
      for (int k = 0; k < CELLS; k++) begin
         hit_a_in[k] = (square[k * CODE_W +: CODE_W] == req_data.first_letter);
         hit_b_in[k] = (square[k * CODE_W +: CODE_W] == req_data.second_letter);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
      s1_req_ff   <= req_data;
      s1_hit_a_ff <= hit_a_in;
      s1_hit_b_ff <= hit_b_in;
   end

   // stage 2: row and column of the first match
   pfc_locate u_locate_a (
      .hit (s1_hit_a_ff),
      .pos (pos_a_in)
   );

   pfc_locate u_locate_b (
      .hit (s1_hit_b_ff),
      .pos (pos_b_in)
   );

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_req_ff   <= s1_req_ff;
      s2_pos_a_ff <= pos_a_in;
      s2_pos_b_ff <= pos_b_in;
   end

   // stage 3: apply the row, column or rectangle rule and fetch the cells
   always_comb begin
      logic dec;
      dec = s2_req_ff.mode;
      rsp_in.not_found = 1'b0;
      priority if (!s2_pos_a_ff.found || !s2_pos_b_ff.found) begin
         rsp_in.first_out  = s2_req_ff.first_letter;
         rsp_in.second_out = s2_req_ff.second_letter;
         rsp_in.not_found  = 1'b1;
      end else if (s2_pos_a_ff.row == s2_pos_b_ff.row) begin
         rsp_in.first_out  = cell_pick(square, s2_pos_a_ff.row,
                                       step_pos(s2_pos_a_ff.col, dec));
         rsp_in.second_out = cell_pick(square, s2_pos_b_ff.row,
                                       step_pos(s2_pos_b_ff.col, dec));
      end else if (s2_pos_a_ff.col == s2_pos_b_ff.col) begin
         rsp_in.first_out  = cell_pick(square, step_pos(s2_pos_a_ff.row, dec),
                                       s2_pos_a_ff.col);
         rsp_in.second_out = cell_pick(square, step_pos(s2_pos_b_ff.row, dec),
                                       s2_pos_b_ff.col);
      end else begin
         rsp_in.first_out  = cell_pick(square, s2_pos_a_ff.row, s2_pos_b_ff.col);
         rsp_in.second_out = cell_pick(square, s2_pos_b_ff.row, s2_pos_a_ff.col);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_rsp_ff <= rsp_in;
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_rsp_ff;

endmodule
